// ----- design/avcc2ab_pkg.sv -----
// Shared types and constants for the AVCC to Annex B reformatter.
// Holds port widths, configuration record phase codes and the result slot type.
// No dependencies.
`default_nettype none

package avcc2ab_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned StampW  = 64;
	localparam int unsigned CountW  = 23;
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 96;
	localparam int unsigned M_TUSER_W = 3;

	// Results that one input word can release at most, and the slot index width.
	localparam int unsigned Slots    = 5;
	localparam int unsigned SlotIdxW = 3;

	localparam logic [StampW-1:0] STAMP_NONE = '1;
	localparam logic [CountW:0]   COUNT_MAX  = 24'd8388607;

	// Last byte index of a frame length prefix and of the record header.
	localparam logic [2:0] PREFIX_LAST = 3'd3;
	localparam logic [2:0] HDR_LAST    = 3'd5;

	// Configuration record phases.
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_HDR  = 4'd1;
	localparam logic [3:0] PH_SPSH = 4'd2;
	localparam logic [3:0] PH_SPSL = 4'd3;
	localparam logic [3:0] PH_SPS  = 4'd4;
	localparam logic [3:0] PH_PPSC = 4'd5;
	localparam logic [3:0] PH_PPSH = 4'd6;
	localparam logic [3:0] PH_PPSL = 4'd7;
	localparam logic [3:0] PH_PPS  = 4'd8;
	localparam logic [3:0] PH_DONE = 4'd9;

	// One output byte together with its first-of-payload mark.
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             first;
	} slot_t;

endpackage

`default_nettype wire

// ----- design/avcc_to_annexb_reformatter_top.sv -----
// The first result released by an accepted word appears on the master side in the next cycle.
// Throughput: frame payloads move one word per cycle while m_tready is high; in a configuration
// record the word that completes an SPS or PPS length releases up to five words, and the slave
// side waits while the batch register drains them, one per cycle with m_tready high.
// Reset (arst_n low, asynchronous): no payload active, no held or pending output, origin all ones.
// Top level of the AVCC to Annex B reformatter; uses avcc2ab_pkg.
`default_nettype none

module avcc_to_annexb_reformatter_top #(
	parameter int unsigned MAX_PAYLOAD = 4194304
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// s_tdata: data_byte [7:0], timestamp [71:8]
	input  wire  [avcc2ab_pkg::S_TDATA_W-1:0]    s_tdata,
	// s_tuser: payload_kind [0], first_byte [1]
	input  wire  [avcc2ab_pkg::S_TUSER_W-1:0]    s_tuser,
	input  wire                                  s_tlast,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// m_tdata: out_byte [7:0], stamp [71:8], total_length [94:72], zero pad [95]
	output logic [avcc2ab_pkg::M_TDATA_W-1:0]    m_tdata,
	// m_tuser: first_out [0], is_config [1], format_error [2]
	output logic [avcc2ab_pkg::M_TUSER_W-1:0]    m_tuser,
	output logic                                 m_tlast
);

	// The output count saturates at the payload limit, but never beyond the field width.
	localparam logic [avcc2ab_pkg::CountW:0] CountCap =
		(MAX_PAYLOAD > 8388607) ? avcc2ab_pkg::COUNT_MAX : (avcc2ab_pkg::CountW+1)'(MAX_PAYLOAD);

	// Input word fields.
	logic [7:0]  in_byte;
	logic [63:0] in_ts;
	logic        in_kind;
	logic        in_first;
	logic        in_last;
	logic        in_acc;

	assign in_byte  = s_tdata[7:0];
	assign in_ts    = s_tdata[71:8];
	assign in_kind  = s_tuser[0];
	assign in_first = s_tuser[1];
	assign in_last  = s_tlast;

	// Payload state.
	logic [63:0] origin_q;
	logic [2:0]  pidx_q;
	logic [31:0] acc_q;
	logic [31:0] brem_q;
	logic [3:0]  phase_q;
	logic [15:0] sps_len_q;
	logic [15:0] pps_len_q;
	logic [22:0] ocount_q;
	logic        active_q;
	logic        cfg_q;
	logic        fpend_q;
	logic [63:0] pstamp_q;
	logic        held_valid_q;
	avcc2ab_pkg::slot_t held_q;

	// Batch register: the results released by one input word, sent one per cycle while m_tready is high.
	logic               bvalid_q;
	logic [2:0]         bn_q;
	avcc2ab_pkg::slot_t bslot_q [avcc2ab_pkg::Slots];
	logic               blast_q;
	logic               bcfg_q;
	logic               berr_q;
	logic [63:0]        bstamp_q;
	logic [22:0]        btotal_q;
	logic [avcc2ab_pkg::SlotIdxW-1:0] idx_q;

	// State as seen by the current word once a payload start has been applied.
	logic        e_active, e_cfg, e_fpend, e_held_valid;
	logic [2:0]  e_pidx;
	logic [31:0] e_acc, e_brem;
	logic [3:0]  e_phase;
	logic [15:0] e_sps, e_pps;
	logic [22:0] e_oc;
	logic [63:0] e_pstamp, e_origin;

	// Next state.
	logic        n_active, n_fpend, n_held_valid;
	logic [2:0]  n_pidx;
	logic [31:0] n_acc, n_brem;
	logic [3:0]  n_phase;
	logic [15:0] n_sps, n_pps;
	logic [22:0] n_oc;
	avcc2ab_pkg::slot_t n_held;

	// Bytes generated by this word, and the combined list behind any held byte.
	avcc2ab_pkg::slot_t gen [4];
	avcc2ab_pkg::slot_t lst [avcc2ab_pkg::Slots];
	avcc2ab_pkg::slot_t nslot [avcc2ab_pkg::Slots];
	logic [2:0]  gcount;
	logic [2:0]  hcount;
	logic [2:0]  nemit;
	logic        nlast;
	logic        nerr;
	logic        start_code;
	logic        pass;
	logic [7:0]  fbyte;
	logic [31:0] acc_shift;
	logic [15:0] new_len;
	logic [31:0] brem_dec;
	logic [23:0] count_sum;

	logic        out_acc;
	logic        last_slot;
	avcc2ab_pkg::slot_t cur;

	always_comb begin
		// A first byte restarts the payload whatever came before.
		e_active     = in_first | active_q;
		e_cfg        = in_first ? in_kind : cfg_q;
		e_fpend      = in_first | fpend_q;
		e_held_valid = in_first ? 1'b0 : held_valid_q;
		e_pidx       = in_first ? 3'd0 : pidx_q;
		e_acc        = in_first ? 32'd0 : acc_q;
		e_brem       = in_first ? 32'd0 : brem_q;
		e_sps        = in_first ? 16'd0 : sps_len_q;
		e_pps        = in_first ? 16'd0 : pps_len_q;
		e_oc         = in_first ? 23'd0 : ocount_q;
		e_origin     = (in_first && in_kind) ? in_ts : origin_q;
		if (in_first) begin
			e_phase  = in_kind ? avcc2ab_pkg::PH_HDR : avcc2ab_pkg::PH_IDLE;
			e_pstamp = in_kind ? avcc2ab_pkg::STAMP_NONE : in_ts - origin_q;
		end else begin
			e_phase  = phase_q;
			e_pstamp = pstamp_q;
		end

		n_active     = e_active;
		n_fpend      = e_fpend;
		n_held_valid = e_held_valid;
		n_held       = held_q;
		n_pidx       = e_pidx;
		n_acc        = e_acc;
		n_brem       = e_brem;
		n_phase      = e_phase;
		n_sps        = e_sps;
		n_pps        = e_pps;

		start_code = 1'b0;
		pass       = 1'b0;
		fbyte      = in_byte;
		acc_shift  = {e_acc[23:0], in_byte};
		new_len    = 16'd0;
		brem_dec   = (e_brem != 32'd0) ? e_brem - 32'd1 : e_brem;

		if (!e_cfg) begin
			// Frame: a length prefix turns into a start code, NAL bytes pass.
			if (e_brem == 32'd0) begin
				fbyte = (e_pidx == avcc2ab_pkg::PREFIX_LAST) ? 8'd1 : 8'd0;
				if (e_pidx >= avcc2ab_pkg::PREFIX_LAST) begin
					n_brem = acc_shift;
					n_acc  = 32'd0;
					n_pidx = 3'd0;
				end else begin
					n_acc  = acc_shift;
					n_pidx = e_pidx + 3'd1;
				end
			end else begin
				n_brem = e_brem - 32'd1;
			end
		end else begin
			unique case (e_phase)
				avcc2ab_pkg::PH_HDR: begin
					if (e_pidx >= avcc2ab_pkg::HDR_LAST) begin
						n_pidx  = 3'd0;
						n_phase = avcc2ab_pkg::PH_SPSH;
					end else begin
						n_pidx = e_pidx + 3'd1;
					end
				end
				avcc2ab_pkg::PH_SPSH: begin
					n_sps   = {in_byte, 8'd0};
					n_phase = avcc2ab_pkg::PH_SPSL;
				end
				avcc2ab_pkg::PH_SPSL: begin
					new_len    = {e_sps[15:8], in_byte};
					n_sps      = new_len;
					start_code = 1'b1;
					n_brem     = {16'd0, new_len};
					n_phase    = (new_len != 16'd0) ? avcc2ab_pkg::PH_SPS
						: avcc2ab_pkg::PH_PPSC;
				end
				avcc2ab_pkg::PH_SPS: begin
					pass   = 1'b1;
					n_brem = brem_dec;
					if (brem_dec == 32'd0) begin
						n_phase = avcc2ab_pkg::PH_PPSC;
					end
				end
				avcc2ab_pkg::PH_PPSC: begin
					n_phase = avcc2ab_pkg::PH_PPSH;
				end
				avcc2ab_pkg::PH_PPSH: begin
					n_pps   = {in_byte, 8'd0};
					n_phase = avcc2ab_pkg::PH_PPSL;
				end
				avcc2ab_pkg::PH_PPSL: begin
					new_len    = {e_pps[15:8], in_byte};
					n_pps      = new_len;
					start_code = 1'b1;
					n_brem     = {16'd0, new_len};
					n_phase    = (new_len != 16'd0) ? avcc2ab_pkg::PH_PPS
						: avcc2ab_pkg::PH_DONE;
				end
				avcc2ab_pkg::PH_PPS: begin
					pass   = 1'b1;
					n_brem = brem_dec;
					if (brem_dec == 32'd0) begin
						n_phase = avcc2ab_pkg::PH_DONE;
					end
				end
				default: begin
					n_phase = avcc2ab_pkg::PH_DONE;
				end
			endcase
		end

		// Generated bytes: one frame byte, a start code, or one SPS/PPS byte.
		for (int k = 0; k < 4; k++) begin
			gen[k] = '{data: 8'd0, first: 1'b0};
		end
		gcount = 3'd0;
		if (!e_cfg) begin
			gen[0].data = fbyte;
			gcount      = 3'd1;
		end else if (start_code) begin
			gen[3].data = 8'd1;
			gcount      = 3'd4;
		end else if (pass) begin
			gen[0].data = in_byte;
			gcount      = 3'd1;
		end
		gen[0].first = e_fpend;
		if (gcount != 3'd0) begin
			n_fpend = 1'b0;
		end

		count_sum = {1'b0, e_oc} + {21'd0, gcount};
		n_oc      = (count_sum > CountCap) ? CountCap[22:0] : count_sum[22:0];

		// Held byte first, then the new ones.
		hcount = {2'd0, e_held_valid};
		if (e_held_valid) begin
			lst[0] = held_q;
			lst[1] = gen[0];
			lst[2] = gen[1];
			lst[3] = gen[2];
			lst[4] = gen[3];
		end else begin
			lst[0] = gen[0];
			lst[1] = gen[1];
			lst[2] = gen[2];
			lst[3] = gen[3];
			lst[4] = '{data: 8'd0, first: 1'b0};
		end

		nslot = lst;
		nemit = 3'd0;
		nlast = 1'b0;
		nerr  = 1'b0;
		if (!e_active) begin
			nemit = 3'd0;
		end else if (!e_cfg) begin
			nemit = 3'd1;
			nlast = in_last;
			if (in_last) begin
				n_active = 1'b0;
			end
		end else if (in_last) begin
			// Record closes: release everything; an empty record gets a marker.
			nlast = 1'b1;
			nerr  = (n_phase != avcc2ab_pkg::PH_DONE);
			if (hcount + gcount == 3'd0) begin
				nemit    = 3'd1;
				nslot[0] = '{data: 8'd0, first: 1'b1};
			end else begin
				nemit = hcount + gcount;
			end
			n_held_valid = 1'b0;
			n_active     = 1'b0;
			n_phase      = avcc2ab_pkg::PH_IDLE;
		end else if (gcount != 3'd0) begin
			// Keep the newest byte back so that it can carry the end mark later.
			nemit        = hcount + gcount - 3'd1;
			n_held       = (gcount == 3'd4) ? gen[3] : gen[0];
			n_held_valid = 1'b1;
		end
	end

	assign last_slot = (idx_q == bn_q - 3'd1);
	assign out_acc   = bvalid_q && m_tready;
	assign s_tready  = !bvalid_q || (m_tready && last_slot);
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q     <= avcc2ab_pkg::STAMP_NONE;
			pidx_q       <= 3'd0;
			acc_q        <= 32'd0;
			brem_q       <= 32'd0;
			phase_q      <= avcc2ab_pkg::PH_IDLE;
			sps_len_q    <= 16'd0;
			pps_len_q    <= 16'd0;
			ocount_q     <= 23'd0;
			active_q     <= 1'b0;
			cfg_q        <= 1'b0;
			fpend_q      <= 1'b0;
			pstamp_q     <= 64'd0;
			held_valid_q <= 1'b0;
		end else if (in_acc) begin
			origin_q     <= e_origin;
			pidx_q       <= n_pidx;
			acc_q        <= n_acc;
			brem_q       <= n_brem;
			phase_q      <= n_phase;
			sps_len_q    <= n_sps;
			pps_len_q    <= n_pps;
			ocount_q     <= n_oc;
			active_q     <= n_active;
			cfg_q        <= e_cfg;
			fpend_q      <= n_fpend;
			pstamp_q     <= e_pstamp;
			held_valid_q <= n_held_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			held_q <= n_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (in_acc && nemit != 3'd0) begin
			bvalid_q <= 1'b1;
			idx_q    <= '0;
		end else if (out_acc && last_slot) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (out_acc) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && nemit != 3'd0) begin
			bn_q     <= nemit;
			bslot_q  <= nslot;
			blast_q  <= nlast;
			bcfg_q   <= e_cfg;
			berr_q   <= nerr;
			bstamp_q <= e_pstamp;
			btotal_q <= n_oc;
		end
	end

	assign cur      = bslot_q[idx_q];
	assign m_tvalid = bvalid_q;
	assign m_tlast  = blast_q && last_slot;
	assign m_tdata  = {1'b0,
		(blast_q && last_slot) ? btotal_q : 23'd0,
		cur.first ? bstamp_q : 64'd0,
		cur.data};
	assign m_tuser  = {blast_q && last_slot && berr_q, bcfg_q, cur.first};

endmodule

`default_nettype wire

// ----- design/avcc2ab_chk.sv -----
// Port-level checker for the AVCC to Annex B reformatter, bound to the top level.
// Uses avcc2ab_pkg for port widths.
`default_nettype none

module avcc2ab_chk (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [avcc2ab_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire [avcc2ab_pkg::M_TUSER_W-1:0]  m_tuser,
	input wire                               m_tlast
);

	// A stalled word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
	else $error("output word changed while stalled");

	// The stamp is only carried on the first word of a payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[71:8] == 64'd0)
	else $error("stamp on a word that is not first");

	// The byte count is only carried on the last word of a payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[94:72] == 23'd0)
	else $error("total length on a word that is not last");

	// A format error closes a configuration record.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast && m_tuser[1])
	else $error("format error outside the end of a record");

endmodule

bind avcc_to_annexb_reformatter_top avcc2ab_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
